// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CHK_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also runs during reset.
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tlse_pkg.sv -----
// Types, constants and lookup functions of the temperature LCD segment encoder.
`timescale 1ns / 1ps
`default_nettype none

package tlse_pkg;

    typedef logic [3:0] bcd_t;
    typedef logic [13:0] dec_val_t;

    typedef struct packed {
        logic [14:0] setpoint;
        logic [13:0] actual_temp;
        logic        blank_set;
        logic [15:0] probe_reading;
    } tlse_in_t;

    typedef struct packed {
        logic [3:0] lcd_address;
        logic [7:0] lcd_data;
        logic       last_write;
    } tlse_out_t;

    typedef enum logic [1:0] {
        SET_NUM,
        SET_DASH,
        SET_BLANK
    } set_mode_t;

    // Classified item: index 0 is the thousands digit, 3 the units digit.
    typedef struct packed {
        bcd_t [3:0] act_dig;
        bcd_t [3:0] set_dig;
        set_mode_t  set_mode;
        logic       probe_lit;
    } tlse_rec_t;

    localparam dec_val_t   VALUE_MAX    = 14'd9999;
    localparam logic [7:0] SEG_DASH     = 8'h04;
    localparam logic [7:0] SEG_BLANK    = 8'h00;
    localparam logic [15:0] THRESH_RESET = 16'd2000;
    localparam logic [1:0] STEP_UNITS   = 2'd3;
    localparam logic [2:0] LAST_IDX     = 3'd7;
    localparam logic [1:0] PAIR_SETPT   = 2'd2;
    localparam logic [1:0] PAIR_PROBE   = 2'd3;

    function automatic logic [7:0] seg_lookup(input bcd_t d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'hFA;
            4'd1:    s = 8'h0A;
            4'd2:    s = 8'hD6;
            4'd3:    s = 8'h9E;
            4'd4:    s = 8'h2E;
            4'd5:    s = 8'hBC;
            4'd6:    s = 8'hFC;
            4'd7:    s = 8'h1A;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hBE;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Place value extracted at each front step.
    function automatic dec_val_t step_unit(input logic [1:0] step);
        dec_val_t u;
        unique case (step)
            2'd0:    u = 14'd1000;
            2'd1:    u = 14'd100;
            2'd2:    u = 14'd10;
            default: u = 14'd1;
        endcase
        return u;
    endfunction

    // Leading digit of v (v < 10 * unit): count of multiples not above v.
    function automatic bcd_t digit_of(input dec_val_t v, input dec_val_t unit);
        bcd_t        d;
        logic [17:0] mult;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            mult = 18'(unit) * 18'(k);
            if ({4'd0, v} >= mult) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic dec_val_t clamp_val(input dec_val_t v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ----- design/tlse_queue.sv -----
// Small register FIFO between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module tlse_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/tlse_front.sv -----
// Front part: takes input words, classifies the set value, splits both values into digits.
`timescale 1ns / 1ps
`default_nettype none

module tlse_front
    import tlse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire tlse_in_t    in_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             push,
    output tlse_rec_t        push_rec,
    input  wire logic        full
);

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] thresh_reg, thresh_next;
    dec_val_t    aval_reg, aval_next;
    dec_val_t    sval_reg, sval_next;
    bcd_t [3:0]  adig_reg, adig_next;
    bcd_t [3:0]  sdig_reg, sdig_next;
    set_mode_t   mode_reg, mode_next;
    logic        probe_reg, probe_next;

    logic        accept;
    dec_val_t    unit;
    bcd_t        adig, sdig;
    logic [17:0] aprod, sprod;

    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !busy_reg;

    assign unit  = step_unit(step_reg);
    assign adig  = digit_of(aval_reg, unit);
    assign sdig  = digit_of(sval_reg, unit);
    assign aprod = 18'(unit) * 18'(adig);
    assign sprod = 18'(unit) * 18'(sdig);

    assign push = busy_reg && (step_reg == STEP_UNITS) && !full;

    always_comb
    begin
        push_rec           = '0;
        push_rec.act_dig   = adig_reg;
        push_rec.set_dig   = sdig_reg;
        push_rec.act_dig[3] = aval_reg[3:0];
        push_rec.set_dig[3] = sval_reg[3:0];
        push_rec.set_mode  = mode_reg;
        push_rec.probe_lit = probe_reg;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        thresh_next = thresh_reg;
        aval_next   = aval_reg;
        sval_next   = sval_reg;
        adig_next   = adig_reg;
        sdig_next   = sdig_reg;
        mode_next   = mode_reg;
        probe_next  = probe_reg;

        if (cfg_valid) begin
            thresh_next = cfg_data;
        end

        if (accept) begin
            busy_next  = 1'b1;
            step_next  = '0;
            aval_next  = clamp_val(in_data.actual_temp);
            sval_next  = clamp_val(in_data.setpoint[13:0]);
            probe_next = (in_data.probe_reading < thresh_reg);
            if (in_data.blank_set) begin
                mode_next = SET_BLANK;
            end else if (in_data.setpoint[14] || (in_data.setpoint == '0)) begin
                mode_next = SET_DASH;
            end else begin
                mode_next = SET_NUM;
            end
        end else if (busy_reg) begin
            if (step_reg != STEP_UNITS) begin
                // peel one decimal digit off each value
                adig_next[step_reg] = adig;
                sdig_next[step_reg] = sdig;
                aval_next = aval_reg - aprod[13:0];
                sval_next = sval_reg - sprod[13:0];
                step_next = step_reg + 1'b1;
            end else if (!full) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            thresh_reg <= THRESH_RESET;
        end else begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            thresh_reg <= thresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aval_reg  <= aval_next;
        sval_reg  <= sval_next;
        adig_reg  <= adig_next;
        sdig_reg  <= sdig_next;
        mode_reg  <= mode_next;
        probe_reg <= probe_next;
    end

endmodule

`default_nettype wire

// ----- design/tlse_back.sv -----
// Back part: turns queued digits into eight writes, one per unstalled cycle.
`timescale 1ns / 1ps
`default_nettype none

module tlse_back
    import tlse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tlse_rec_t head,
    input  wire logic      head_valid,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_stall,
    output tlse_out_t      out_data
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    tlse_out_t  out_data_reg, out_data_next;

    logic       advance;
    logic [1:0] pair;
    bcd_t       ad, sd;
    logic       lead_blank;
    logic [7:0] useg, dseg, icon;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign advance = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = advance && (idx_reg == LAST_IDX);
    assign pair    = idx_reg[2:1];
    assign ad      = head.act_dig[pair];
    assign sd      = head.set_dig[pair];

    always_comb
    begin
        // thousands blank below 1000, hundreds blank below 100
        lead_blank = 1'b0;
        if (pair == 2'd0) begin
            lead_blank = 1'b1;
        end else if (pair == 2'd1) begin
            lead_blank = (head.act_dig[0] == '0);
        end
        useg = (lead_blank && (ad == '0)) ? SEG_BLANK : seg_lookup(ad);

        lead_blank = 1'b0;
        if (pair == 2'd0) begin
            lead_blank = 1'b1;
        end else if (pair == 2'd1) begin
            lead_blank = (head.set_dig[0] == '0);
        end
        unique case (head.set_mode)
            SET_NUM:   dseg = (lead_blank && (sd == '0)) ? SEG_BLANK : seg_lookup(sd);
            SET_DASH:  dseg = SEG_DASH;
            default:   dseg = SEG_BLANK;
        endcase

        icon = 8'h00;
        if (pair == PAIR_SETPT) begin
            icon = {(head.set_mode == SET_NUM), 6'd0, 1'b1};
        end else if (pair == PAIR_PROBE) begin
            icon = {1'b1, 6'd0, head.probe_lit};
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            idx_next                  = idx_reg + 1'b1;
            out_valid_next            = 1'b1;
            out_data_next.lcd_address = {idx_reg, 1'b0};
            out_data_next.last_write  = (idx_reg == LAST_IDX);
            if (idx_reg[0]) begin
                out_data_next.lcd_data = icon | {1'b0, dseg[3:0], 3'b000}
                                       | {4'b0000, useg[3:1], 1'b0};
            end else begin
                out_data_next.lcd_data = {dseg[7:4], useg[7:4]};
            end
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- design/temperature_lcd_segment_encoder.sv -----
// Top level of the temperature LCD segment encoder.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall   | tlse_in_t: set, actual, blank, probe
//  out     | output    | out_valid/out_stall | tlse_out_t: address, data, last
//  cfg     | input     | cfg_valid/cfg_ready | probe_threshold, 16 bit
//
// One input word gives eight output words; the back part emits one word per
// cycle while out_stall is low and the queue holds a word.
// The front works through accept, three digit steps and queue push, stalling the input meanwhile.
// out_valid for the first output word rises after the digit steps, the queue and the output register.
// Reset clears the control state and sets the threshold to 2000.
// A stalled output holds the back part; the queue lets the front keep going until it is full.
`timescale 1ns / 1ps
`default_nettype none

module temperature_lcd_segment_encoder
    import tlse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire tlse_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output tlse_out_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic      push, full, pop, empty;
    tlse_rec_t push_rec, head;

    tlse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full)
    );

    tlse_queue #(
        .WIDTH ($bits(tlse_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_rec),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    tlse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ----- design/tlse_checker.sv -----
// Port-level checks of the encoder and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlse_checker
    import tlse_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire tlse_out_t out_data
);

    // held word must not change
    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "output word changed while stalled")

    `CHK_ASSERT(a_addr_even, clk, rst_n, out_valid |-> !out_data.lcd_address[0], "odd display address")

    `CHK_ASSERT(a_last_addr, clk, rst_n, out_valid |-> (out_data.last_write == (out_data.lcd_address == 4'd14)), "last flag not on address 14")

    // words of one run follow each other in address order
    `CHK_ASSERT(a_addr_step, clk, rst_n, (out_valid && !out_stall && !out_data.last_write) ##1 out_valid |-> out_data.lcd_address == $past(out_data.lcd_address) + 4'd2, "address sequence broken")

endmodule

bind temperature_lcd_segment_encoder tlse_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
